// ----- rtl/bppq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bppq_pkg
// Types, register indexes, event codes and reset values for the beam pulse
// presence qualifier.
// ----------------------------------------------------------------------------
package bppq_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TH_W        = 12;
  localparam int PERIOD_W    = 16;
  localparam int COUNT_W     = 4;
  localparam int EVENT_W     = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CMP_W       = (SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FAIL =
    SAMPLE_BITS'((2 ** SAMPLE_BITS) - 3);

  localparam logic [CFG_ADDR_W-1:0] REG_ON_THRESHOLD     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS_WIDTH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PERIOD       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PERIOD       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOST_TIMEOUT     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CONFIRM_COUNT    = 3'd5;

  localparam logic [TH_W-1:0]     RST_ON_THRESHOLD     = 12'd200;
  localparam logic [TH_W-1:0]     RST_HYSTERESIS_WIDTH = 12'd120;
  localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD       = 16'd600;
  localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD       = 16'd1300;
  localparam logic [PERIOD_W-1:0] RST_LOST_TIMEOUT     = 16'd2500;
  localparam logic [COUNT_W-1:0]  RST_CONFIRM_COUNT    = 4'd3;

  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_AMPFAIL = 3'd1;
  localparam logic [EVENT_W-1:0] EV_SHORT   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_PULSE   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LIGHT   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd5;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  typedef struct packed {
    logic [TH_W-1:0]     on_threshold;
    logic [TH_W-1:0]     hysteresis_width;
    logic [PERIOD_W-1:0] min_period;
    logic [PERIOD_W-1:0] max_period;
    logic [PERIOD_W-1:0] lost_timeout;
    logic [COUNT_W-1:0]  confirm_count;
  } cfg_t;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic                light_present;
    logic [EVENT_W-1:0]  event_code;
    logic                amplitude_ok;
    logic [COUNT_W-1:0]  pulse_count;
    logic [PERIOD_W-1:0] elapsed_ticks;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/bppq_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bppq_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bppq_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [bppq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bppq_pkg::CFG_DATA_W-1:0] cfg_data,
  output bppq_pkg::cfg_t                      cfg
);
  import bppq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_threshold     <= RST_ON_THRESHOLD;
      cfg.hysteresis_width <= RST_HYSTERESIS_WIDTH;
      cfg.min_period       <= RST_MIN_PERIOD;
      cfg.max_period       <= RST_MAX_PERIOD;
      cfg.lost_timeout     <= RST_LOST_TIMEOUT;
      cfg.confirm_count    <= RST_CONFIRM_COUNT;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_ON_THRESHOLD:     cfg.on_threshold     <= cfg_data[TH_W-1:0];
        REG_HYSTERESIS_WIDTH: cfg.hysteresis_width <= cfg_data[TH_W-1:0];
        REG_MIN_PERIOD:       cfg.min_period       <= cfg_data[PERIOD_W-1:0];
        REG_MAX_PERIOD:       cfg.max_period       <= cfg_data[PERIOD_W-1:0];
        REG_LOST_TIMEOUT:     cfg.lost_timeout     <= cfg_data[PERIOD_W-1:0];
        REG_CONFIRM_COUNT:    cfg.confirm_count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bppq_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bppq_core
// Qualifier state and the single-pass step: hysteresis check, period checks,
// pulse counting and the lost-beam timer.
// ----------------------------------------------------------------------------
module bppq_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bppq_pkg::cfg_t     cfg,
  input  wire logic               step_en,
  input  wire bppq_pkg::in_item_t item,
  output bppq_pkg::out_item_t     result
);
  import bppq_pkg::*;

  logic                timer_running;
  logic                light_flag;
  logic                amplitude_state;
  logic [COUNT_W-1:0]  valid_pulses;
  logic [PERIOD_W-1:0] elapsed_counter;

  logic                timer_running_next;
  logic                light_flag_next;
  logic                amplitude_state_next;
  logic [COUNT_W-1:0]  valid_pulses_next;
  logic [PERIOD_W-1:0] elapsed_counter_next;

  logic [TH_W-1:0]     off_th;
  logic [CMP_W-1:0]    sample_x;
  logic [CMP_W-1:0]    on_x;
  logic [CMP_W-1:0]    off_x;
  logic [PERIOD_W-1:0] cnt_inc;
  logic [EVENT_W-1:0]  event_code;
  logic [PERIOD_W-1:0] shown;

  always_comb begin
    off_th   = (cfg.on_threshold > cfg.hysteresis_width) ?
               (cfg.on_threshold - cfg.hysteresis_width) : '0;
    sample_x = CMP_W'(item.adc_sample);
    on_x     = CMP_W'(cfg.on_threshold);
    off_x    = CMP_W'(off_th);
    cnt_inc  = elapsed_counter + 1'b1;

    timer_running_next   = timer_running;
    light_flag_next      = light_flag;
    amplitude_state_next = amplitude_state;
    valid_pulses_next    = valid_pulses;
    elapsed_counter_next = elapsed_counter;
    event_code           = EV_NONE;
    shown                = elapsed_counter;

    if (item.mode == MODE_TICK) begin
      if (timer_running) begin
        if (cnt_inc >= cfg.lost_timeout) begin
          timer_running_next   = 1'b0;
          light_flag_next      = 1'b0;
          amplitude_state_next = 1'b0;
          valid_pulses_next    = '0;
          elapsed_counter_next = '0;
          event_code           = EV_TIMEOUT;
          shown                = '0;
        end else begin
          elapsed_counter_next = cnt_inc;
          shown                = cnt_inc;
        end
      end
    end else begin
      if (item.adc_sample >= SAMPLE_FAIL) begin
        amplitude_state_next = 1'b0;
      end else if (!amplitude_state) begin
        amplitude_state_next = (sample_x >= on_x);
      end else begin
        amplitude_state_next = !(sample_x <= off_x);
      end

      if (!amplitude_state_next) begin
        event_code = EV_AMPFAIL;
      end else if (timer_running && (elapsed_counter < cfg.min_period)) begin
        event_code = EV_SHORT;
      end else begin
        if (timer_running && (elapsed_counter > cfg.max_period)) begin
          valid_pulses_next = light_flag ? cfg.confirm_count : COUNT_W'(1);
        end else if (valid_pulses < cfg.confirm_count) begin
          valid_pulses_next = valid_pulses + 1'b1;
        end
        timer_running_next   = 1'b1;
        elapsed_counter_next = '0;
        if (!light_flag && (valid_pulses_next >= cfg.confirm_count)) begin
          light_flag_next = 1'b1;
          event_code      = EV_LIGHT;
        end else begin
          event_code = EV_PULSE;
        end
      end
    end

    result.light_present = light_flag_next;
    result.event_code    = event_code;
    result.amplitude_ok  = amplitude_state_next;
    result.pulse_count   = valid_pulses_next;
    result.elapsed_ticks = shown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_running   <= 1'b0;
      light_flag      <= 1'b0;
      amplitude_state <= 1'b0;
      valid_pulses    <= '0;
      elapsed_counter <= '0;
    end else if (step_en) begin
      timer_running   <= timer_running_next;
      light_flag      <= light_flag_next;
      amplitude_state <= amplitude_state_next;
      valid_pulses    <= valid_pulses_next;
      elapsed_counter <= elapsed_counter_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    step_en && (event_code == EV_TIMEOUT) |=>
      !timer_running && !light_flag && (valid_pulses == '0) && (elapsed_counter == '0))
    else $error("timeout left state behind");

  a_ampfail_holds: assert property (@(posedge clk) disable iff (rst)
    step_en && (event_code == EV_AMPFAIL) |=>
      $stable(elapsed_counter) && $stable(valid_pulses) && !amplitude_state)
    else $error("amplitude fail changed timer or count");

  a_light_on: assert property (@(posedge clk) disable iff (rst)
    step_en && (event_code == EV_LIGHT) |=> light_flag && timer_running)
    else $error("light on event without light flag");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(valid_pulses) && $stable(elapsed_counter) && $stable(light_flag))
    else $error("state moved without a step");
`endif

endmodule
`default_nettype wire

// ----- rtl/beam_pulse_presence_qualifier.sv -----
`default_nettype none
// Path: an accepted input is loaded into the input register, then into the
//   result register, which raises out_valid.
// Throughput: one transaction per cycle while out_stall does not hold the
//   pipeline; the state update fits between the two registers.
// Reset: synchronous rst clears the pipeline valids and qualifier state and
//   loads the configuration defaults.
// ----------------------------------------------------------------------------
// beam_pulse_presence_qualifier
// Pulsed infrared beam qualifier: input register, single-pass step and
// result register with valid/stall handshakes.
// ----------------------------------------------------------------------------
module beam_pulse_presence_qualifier (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [bppq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bppq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire bppq_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output bppq_pkg::out_item_t                  out_data
);
  import bppq_pkg::*;

  cfg_t      cfg;
  logic      in_q_valid;
  in_item_t  in_q;
  out_item_t result;
  logic      advance;
  logic      step_en;

  bppq_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bppq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (step_en),
    .item    (in_q),
    .result  (result)
  );

  assign advance  = !out_valid || !out_stall;
  assign step_en  = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (step_en) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire
